[rtl/core/blaf_pkg.sv]
// ----------------------------------------------------------------------------
// blaf_pkg
// Types and codes shared by the link acknowledgement and flow control core.
// ----------------------------------------------------------------------------
package blaf_pkg;

    localparam logic [1:0] KIND_GOOD    = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_SENT    = 2'd3;

    localparam logic [1:0] PDU_CTRL  = 2'd0;
    localparam logic [1:0] PDU_DATA  = 2'd1;
    localparam logic [1:0] PDU_EMPTY = 2'd2;

    localparam logic [1:0] SRC_EMPTY  = 2'd0;
    localparam logic [1:0] SRC_CTRL   = 2'd1;
    localparam logic [1:0] SRC_DATA   = 2'd2;
    localparam logic [1:0] SRC_REPEAT = 2'd3;

    localparam logic [1:0] REL_NONE = 2'd0;
    localparam logic [1:0] REL_CTRL = 2'd1;
    localparam logic [1:0] REL_DATA = 2'd2;

    localparam logic [1:0] STO_NONE = 2'd0;
    localparam logic [1:0] STO_CTRL = 2'd1;
    localparam logic [1:0] STO_DATA = 2'd2;

    localparam logic [8:0] HDR_BYTES = 9'd2;
    localparam logic [8:0] MIC_BYTES = 9'd4;

    // Members are listed from the highest bit down, so the first field of
    // the stream word sits in the lowest bits.
    typedef struct packed {
        logic       data_in_full;
        logic [2:0] ctrl_in_free;
        logic [3:0] data_out_count;
        logic       ctrl_wait;
        logic [2:0] ctrl_out_count;
        logic [7:0] rx_length;
        logic       rx_is_control;
        logic       rx_md;
        logic       rx_nesn;
        logic       rx_sn;
    } in_item_t;

    typedef struct packed {
        logic       continue_rx;
        logic       end_event;
        logic [8:0] store_bytes;
        logic [1:0] store_to;
        logic [1:0] release_last;
        logic       tx_md;
        logic       tx_nesn;
        logic       tx_sn;
        logic [1:0] tx_source;
        logic       tx_send;
    } result_t;

    typedef struct packed {
        logic       own_sn;
        logic       own_nesn;
        logic [1:0] last_pdu_kind;
        logic       peer_more_data;
    } link_state_t;

endpackage

[rtl/core/ble_link_ack_flow_control_core.sv]
// ----------------------------------------------------------------------------
// ble_link_ack_flow_control_core
// Peripheral-side SN/NESN acknowledgement and flow control of a connection
// event, one result request for each event request.
// ----------------------------------------------------------------------------
// Each event request is captured in an input register, decided by a short
// layer of logic against the link state, and placed in a result register, so
// a new event is taken every cycle while the output is not stalled. The
// result is held in the result register until the output side takes it; a
// stalled output holds the input register and then the input side.
// The link state (SN, NESN, last PDU kind, peer more-data) is updated in the
// same cycle that an event moves into the result register, which keeps events
// strictly in order. The encryption register is written through the cfg
// channel, which is always ready, and must only be changed while no event is
// in flight.
module ble_link_ack_flow_control_core #(
    parameter int CTRL_SLOTS    = 4,
    parameter int DATA_SLOTS    = 8,
    parameter int MAX_RX_OCTETS = 251
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_sn, rx_nesn, rx_md, rx_is_control, rx_length[7:0], ctrl_out_count[2:0],
    // ctrl_wait, data_out_count[3:0], ctrl_in_free[2:0], data_in_full
    input  logic [23:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_send, tx_source[1:0], tx_sn, tx_nesn, tx_md, release_last[1:0],
    // store_to[1:0], store_bytes[8:0], end_event, continue_rx, zero padding
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import blaf_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    link_state_t state_reg;
    link_state_t state_next;
    result_t     res_next;
    logic        enc_reg;
    logic        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, res_reg};

    blaf_decide #(
        .CTRL_SLOTS   (CTRL_SLOTS),
        .DATA_SLOTS   (DATA_SLOTS),
        .MAX_RX_OCTETS(MAX_RX_OCTETS)
    ) u_decide (
        .kind         (in_kind_reg),
        .item         (in_item_reg),
        .state        (state_reg),
        .encryption_on(enc_reg),
        .result       (res_next),
        .state_next   (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            enc_reg                 <= 1'b0;
            state_reg.own_sn        <= 1'b0;
            state_reg.own_nesn      <= 1'b0;
            state_reg.last_pdu_kind <= PDU_EMPTY;
            state_reg.peer_more_data <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                enc_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_item_reg <= in_item_t'(s_tdata);
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_good_sends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_GOOD) |=> (m_tvalid && res_reg.tx_send))
        else $error("good packet event produced no transmission");

    a_sn_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance || in_kind_reg != KIND_GOOD) |=> $stable(state_reg.own_sn))
        else $error("SN changed without a good packet event");

    a_store_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((res_reg.store_to == STO_NONE) == (res_reg.store_bytes == 9'd0)))
        else $error("store target and stored byte count disagree");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

[rtl/core/blaf_decide.sv]
// ----------------------------------------------------------------------------
// blaf_decide
// Combinational decision for one event: acknowledgement, storage, response
// selection and the next link state.
// ----------------------------------------------------------------------------
module blaf_decide #(
    parameter int CTRL_SLOTS    = 4,
    parameter int DATA_SLOTS    = 8,
    parameter int MAX_RX_OCTETS = 251
) (
    input  logic [1:0]           kind,
    input  blaf_pkg::in_item_t   item,
    input  blaf_pkg::link_state_t state,
    input  logic                 encryption_on,
    output blaf_pkg::result_t    result,
    output blaf_pkg::link_state_t state_next
);
    import blaf_pkg::*;

    localparam logic [2:0] CTRL_CAP = (CTRL_SLOTS > 7) ? 3'd7 : 3'(CTRL_SLOTS);
    localparam logic [3:0] DATA_CAP = (DATA_SLOTS > 15) ? 4'd15 : 4'(DATA_SLOTS);
    localparam logic [7:0] MAX_LEN  = 8'(MAX_RX_OCTETS);

    logic [2:0] c_out;
    logic [3:0] d_sat;
    logic [3:0] d_out;
    logic       room;
    logic       accept;
    logic       acked;

    assign c_out  = (item.ctrl_out_count > CTRL_CAP) ? CTRL_CAP : item.ctrl_out_count;
    assign d_sat  = (item.data_out_count > DATA_CAP) ? DATA_CAP : item.data_out_count;
    assign room   = item.rx_is_control ? (item.ctrl_in_free != 3'd0) : !item.data_in_full;
    assign accept = (item.rx_sn == state.own_nesn) && room && (item.rx_length <= MAX_LEN);
    assign acked  = (item.rx_nesn != state.own_sn);
    assign d_out  = (acked && state.last_pdu_kind == PDU_DATA && d_sat != 4'd0)
                    ? d_sat - 4'd1 : d_sat;

    always_comb
    begin
        result     = '0;
        state_next = state;
        unique case (kind)
            KIND_GOOD:
            begin
                state_next.peer_more_data = item.rx_md;
                if (accept)
                begin
                    state_next.own_nesn = !state.own_nesn;
                    if (item.rx_length != 8'd0)
                    begin
                        result.store_to    = item.rx_is_control ? STO_CTRL : STO_DATA;
                        result.store_bytes = HDR_BYTES + 9'(item.rx_length)
                                             + (encryption_on ? MIC_BYTES : 9'd0);
                    end
                end
                if (acked)
                begin
                    if (state.last_pdu_kind == PDU_CTRL)
                    begin
                        result.release_last = REL_CTRL;
                    end
                    else if (state.last_pdu_kind == PDU_DATA)
                    begin
                        result.release_last = REL_DATA;
                    end
                    state_next.own_sn = !state.own_sn;
                    if (c_out != 3'd0 && !item.ctrl_wait)
                    begin
                        result.tx_source         = SRC_CTRL;
                        result.tx_md             = (c_out > 3'd1) || (d_out != 4'd0);
                        state_next.last_pdu_kind = PDU_CTRL;
                    end
                    else if (d_out != 4'd0)
                    begin
                        result.tx_source         = SRC_DATA;
                        result.tx_md             = (d_out > 4'd1);
                        state_next.last_pdu_kind = PDU_DATA;
                    end
                    else
                    begin
                        result.tx_source         = SRC_EMPTY;
                        state_next.last_pdu_kind = PDU_EMPTY;
                    end
                end
                else
                begin
                    if (state.last_pdu_kind == PDU_CTRL || state.last_pdu_kind == PDU_DATA)
                    begin
                        result.tx_source = SRC_REPEAT;
                    end
                    else
                    begin
                        result.tx_source         = SRC_EMPTY;
                        state_next.last_pdu_kind = PDU_EMPTY;
                    end
                end
                result.tx_send = 1'b1;
                result.tx_sn   = state_next.own_sn;
                result.tx_nesn = state_next.own_nesn;
            end
            KIND_SENT:
            begin
                result.continue_rx = state.peer_more_data;
                result.end_event   = !state.peer_more_data;
            end
            KIND_CRC, KIND_TIMEOUT:
            begin
                result.end_event = 1'b1;
            end
            default:
            begin
                result.end_event = 1'b1;
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the link acknowledgement and flow control core. A
// directed table covers the event kinds, the field extremes and the SN/NESN
// corner cases, then random connection events follow with the encryption
// setting changed between phases. Every result request is checked field by
// field against an in-order queue filled by a behavioral predictor or by typed table rows.
// ----------------------------------------------------------------------------
module tb_top;
    import blaf_pkg::*;

    localparam int CTRL_SLOTS    = 4;
    localparam int DATA_SLOTS    = 8;
    localparam int MAX_RX_OCTETS = 251;
    localparam int PHASE_ITEMS   = 140;

    typedef struct {
        bit         is_cfg;
        bit         cfg_val;
        logic [1:0] kind;
        in_item_t   item;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    logic        link_sn;
    logic        link_nesn;
    logic [1:0]  prev_pdu;
    logic        peer_more;
    logic        crypt_on;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];
    int          errors = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    ble_link_ack_flow_control_core #(
        .CTRL_SLOTS   (CTRL_SLOTS),
        .DATA_SLOTS   (DATA_SLOTS),
        .MAX_RX_OCTETS(MAX_RX_OCTETS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic in_item_t pkt(logic sn, logic nesn, logic md, logic ctl,
                                     logic [7:0] len, logic [2:0] c_out, logic c_wait,
                                     logic [3:0] d_out, logic [2:0] c_free, logic d_full);
        in_item_t it;
        it.rx_sn          = sn;
        it.rx_nesn        = nesn;
        it.rx_md          = md;
        it.rx_is_control  = ctl;
        it.rx_length      = len;
        it.ctrl_out_count = c_out;
        it.ctrl_wait      = c_wait;
        it.data_out_count = d_out;
        it.ctrl_in_free   = c_free;
        it.data_in_full   = d_full;
        return it;
    endfunction

    function automatic result_t res(logic send, logic [1:0] src, logic sn, logic nesn,
                                    logic md, logic [1:0] rel, logic [1:0] sto,
                                    logic [8:0] bytes, logic endev, logic cont);
        result_t r;
        r.tx_send      = send;
        r.tx_source    = src;
        r.tx_sn        = sn;
        r.tx_nesn      = nesn;
        r.tx_md        = md;
        r.release_last = rel;
        r.store_to     = sto;
        r.store_bytes  = bytes;
        r.end_event    = endev;
        r.continue_rx  = cont;
        return r;
    endfunction

    function automatic stim_row_t ev(logic [1:0] kind, in_item_t it, bit typed,
                                     result_t want);
        stim_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_val = 1'b0;
        row.kind    = kind;
        row.item    = it;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(bit v);
        stim_row_t row;
        row = ev(KIND_GOOD, '0, 1'b0, '0);
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    // Advances the link state by one event and returns the response it causes.
    function automatic result_t decide_response(logic [1:0] kind, in_item_t it);
        result_t    r;
        logic       room;
        logic       take;
        logic [2:0] c_out;
        logic [3:0] d_out;
        r = '0;
        c_out = (it.ctrl_out_count > CTRL_SLOTS) ? 3'(CTRL_SLOTS) : it.ctrl_out_count;
        d_out = (it.data_out_count > DATA_SLOTS) ? 4'(DATA_SLOTS) : it.data_out_count;
        if (kind == KIND_GOOD)
        begin
            room = it.rx_is_control ? (it.ctrl_in_free != 0) : !it.data_in_full;
            take = (it.rx_sn == link_nesn) && room && (it.rx_length <= MAX_RX_OCTETS);
            peer_more = it.rx_md;
            if (take)
            begin
                link_nesn = ~link_nesn;
                if (it.rx_length != 0)
                begin
                    r.store_to    = it.rx_is_control ? STO_CTRL : STO_DATA;
                    r.store_bytes = HDR_BYTES + {1'b0, it.rx_length}
                                    + (crypt_on ? MIC_BYTES : 9'd0);
                end
            end
            if (it.rx_nesn != link_sn)
            begin
                if (prev_pdu == PDU_CTRL)
                    r.release_last = REL_CTRL;
                else if (prev_pdu == PDU_DATA)
                begin
                    r.release_last = REL_DATA;
                    if (d_out != 0)
                        d_out = d_out - 4'd1;
                end
                link_sn = ~link_sn;
                if (c_out != 0 && !it.ctrl_wait)
                begin
                    r.tx_source = SRC_CTRL;
                    r.tx_md     = (c_out > 1) || (d_out != 0);
                    prev_pdu    = PDU_CTRL;
                end
                else if (d_out != 0)
                begin
                    r.tx_source = SRC_DATA;
                    r.tx_md     = d_out > 1;
                    prev_pdu    = PDU_DATA;
                end
                else
                begin
                    r.tx_source = SRC_EMPTY;
                    prev_pdu    = PDU_EMPTY;
                end
            end
            else if (prev_pdu == PDU_CTRL || prev_pdu == PDU_DATA)
                r.tx_source = SRC_REPEAT;
            else
            begin
                r.tx_source = SRC_EMPTY;
                prev_pdu    = PDU_EMPTY;
            end
            r.tx_send = 1'b1;
            r.tx_sn   = link_sn;
            r.tx_nesn = link_nesn;
        end
        else if (kind == KIND_SENT)
        begin
            r.continue_rx = peer_more;
            r.end_event   = !peer_more;
        end
        else
            r.end_event = 1'b1;
        return r;
    endfunction

    // A received packet that mostly follows the sequence numbers of the link.
    function automatic in_item_t wellformed_pkt();
        in_item_t it;
        int       pick;
        it = pkt(($urandom_range(7) == 0) ? ~link_nesn : link_nesn,
                 ($urandom_range(4) == 0) ? link_sn : ~link_sn,
                 1'($urandom_range(1)), $urandom_range(9) < 3, 8'd0,
                 3'($urandom_range(7)), $urandom_range(3) == 0, 4'($urandom_range(15)),
                 3'($urandom_range(7)), $urandom_range(4) == 0);
        pick = $urandom_range(99);
        if (pick < 8)
            it.rx_length = 8'd0;
        else if (pick < 16)
            it.rx_length = 8'd251;
        else if (pick < 20)
            it.rx_length = 8'($urandom_range(252, 255));
        else if (pick < 60)
            it.rx_length = 8'($urandom_range(1, 40));
        else
            it.rx_length = 8'($urandom_range(41, 250));
        return it;
    endfunction

    task automatic send_event(logic [1:0] kind, in_item_t it, bit typed, result_t want);
        result_t model;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= it;
        do @(posedge clk); while (!s_tready);
        model = decide_response(kind, it);
        pending_results.push_back(typed ? want : model);
    endtask

    task automatic source_gap();
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic write_crypt(bit v);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        crypt_on = v;
    endtask

    always @(posedge clk)
    begin : response_check
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[20:0];
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected response %h with no request outstanding", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.tx_send !== want.tx_send || got.tx_source !== want.tx_source
                    || got.tx_sn !== want.tx_sn || got.tx_nesn !== want.tx_nesn
                    || got.tx_md !== want.tx_md || got.release_last !== want.release_last
                    || got.store_to !== want.store_to
                    || got.store_bytes !== want.store_bytes
                    || got.end_event !== want.end_event
                    || got.continue_rx !== want.continue_rx || m_tdata[23:21] !== 3'b000)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %h, got %h", {3'b000, want}, m_tdata);
                end
            end
        end
        if (stall_left > 0 && !quiet)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < snk_idle_pct)
        begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int       n;
        int       pick;
        logic [23:0] raw;
        in_item_t it;
        link_sn   = 1'b0;
        link_nesn = 1'b0;
        prev_pdu  = PDU_EMPTY;
        peer_more = 1'b0;
        crypt_on  = 1'b0;

        directed_rows.push_back(ev(KIND_SENT, '0, 1'b1,
            res(0, SRC_EMPTY, 0, 0, 0, REL_NONE, STO_NONE, 0, 1, 0)));
        directed_rows.push_back(ev(KIND_CRC, pkt(1, 1, 1, 1, 255, 7, 1, 15, 7, 1), 1'b1,
            res(0, SRC_EMPTY, 0, 0, 0, REL_NONE, STO_NONE, 0, 1, 0)));
        directed_rows.push_back(ev(KIND_TIMEOUT, pkt(1, 1, 1, 1, 255, 7, 1, 15, 7, 1), 1'b1,
            res(0, SRC_EMPTY, 0, 0, 0, REL_NONE, STO_NONE, 0, 1, 0)));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            res(1, SRC_EMPTY, 0, 1, 0, REL_NONE, STO_NONE, 0, 0, 0)));
        directed_rows.push_back(ev(KIND_SENT, '0, 1'b1,
            res(0, SRC_EMPTY, 0, 0, 0, REL_NONE, STO_NONE, 0, 0, 1)));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 1, 0, 0, 251, 7, 0, 15, 0, 0), 1'b1,
            res(1, SRC_CTRL, 1, 0, 1, REL_NONE, STO_DATA, 253, 0, 0)));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 1, 0, 1, 1, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 1, 1, 27, 1, 1, 1, 4, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 1, 0, 0, 5, 0, 0, 2, 3, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 1, 1, 0, 10, 2, 0, 3, 1, 1), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 0, 0, 0, 252, 0, 0, 15, 0, 0), 0, '0));
        directed_rows.push_back(ev(KIND_SENT, '0, 0, '0));
        directed_rows.push_back(cfg_row(1'b1));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 1, 0, 0, 251, 7, 0, 0, 7, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 0, 0, 251, 1, 0, 1, 0, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 0, 1, 255, 0, 0, 0, 4, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 1, 0, 1, 64, 0, 0, 0, 1, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.push_back(ev(KIND_GOOD, pkt(0, 0, 1, 1, 200, 4, 0, 8, 4, 1), 0, '0));
        directed_rows.push_back(ev(KIND_SENT, '0, 0, '0));
        directed_rows.push_back(ev(KIND_CRC, '0, 0, '0));
        directed_rows.push_back(ev(KIND_TIMEOUT, '0, 0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_crypt(directed_rows[i].cfg_val);
            else
                send_event(directed_rows[i].kind, directed_rows[i].item,
                           directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            write_crypt(1'(ph % 2));
            case (ph)
                0:
                begin
                    src_idle_pct = 25;
                    snk_idle_pct = 10;
                end
                1:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 10;
                    snk_idle_pct = 30;
                end
                3:
                begin
                    src_idle_pct = 40;
                    snk_idle_pct = 15;
                end
                4:
                begin
                    src_idle_pct = 15;
                    snk_idle_pct = 40;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    quiet        = 1'b1;
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    send_event(KIND_GOOD, wellformed_pkt(), 1'b0, '0);
                    n++;
                    source_gap();
                    if ($urandom_range(4) != 0)
                    begin
                        raw = 24'($urandom);
                        send_event(KIND_SENT, raw, 1'b0, '0);
                        n++;
                        source_gap();
                    end
                end
                else
                begin
                    raw = 24'($urandom);
                    it  = raw;
                    send_event(2'($urandom_range(3)), it, 1'b0, '0);
                    n++;
                    source_gap();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        errors += pending_results.size();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
